[rtl/round_robin_voice_allocator_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the voice allocator
// Concurrent assertion helpers, compiled out in synthesis.
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define ROUND_ROBIN_VOICE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RRVA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
    else $error("voice allocator assertion failed");

// next-cycle implication
`define RRVA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> cons) \
    else $error("voice allocator assertion failed");

`else

`define RRVA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RRVA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/rrva_pkg.sv]
// ---------------------------------------------------------------------------
// Voice allocator package
// Shared constants, register map, state codes and control structs.
// ---------------------------------------------------------------------------
`default_nettype none

package rrva_pkg;

  // note codes
  localparam logic [6:0] NOTE_OFF = 7'd120;
  localparam logic [6:0] NOTE_TOP = 7'd119;

  // register map
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_OCTAVE_SHIFT = 2'd0;
  localparam logic [1:0] REG_TRACK_COUNT  = 2'd1;
  localparam logic [1:0] REG_INSTRUMENT   = 2'd2;

  // register reset values
  localparam logic [3:0] OCTAVE_RST = 4'd4;
  localparam logic [5:0] TRACKS_RST = 6'd32;
  localparam logic [7:0] INSTR_RST  = 8'd0;

  typedef struct packed {
    logic [3:0] octave_shift;
    logic [5:0] track_count;
    logic [7:0] instrument;
  } cfg_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_STEAL,
    S_SDRAIN,
    S_STORE,
    S_FLUSH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_cnt;
    logic issue;
    logic pass_steal;
    logic store;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_addr;
    logic is_release;
    logic need_steal;
  } sts_t;

endpackage

`default_nettype wire

[rtl/rrva_regs.sv]
// ---------------------------------------------------------------------------
// Voice allocator configuration registers
// APB-style register file for octave shift, track count and instrument.
// ---------------------------------------------------------------------------
`default_nettype none

module rrva_regs
  import rrva_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_shift <= OCTAVE_RST;
      cfg_q.track_count  <= TRACKS_RST;
      cfg_q.instrument   <= INSTR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OCTAVE_SHIFT: cfg_q.octave_shift <= pwdata[3:0];
        REG_TRACK_COUNT:  cfg_q.track_count  <= pwdata[5:0];
        REG_INSTRUMENT:   cfg_q.instrument   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_idx)
      REG_OCTAVE_SHIFT: prdata = {28'd0, cfg_q.octave_shift};
      REG_TRACK_COUNT:  prdata = {26'd0, cfg_q.track_count};
      REG_INSTRUMENT:   prdata = {24'd0, cfg_q.instrument};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/rrva_ctrl.sv]
// ---------------------------------------------------------------------------
// Voice allocator controller
// Sequences the release/search scan, the optional steal scan and the store.
// ---------------------------------------------------------------------------
`default_nettype none

module rrva_ctrl
  import rrva_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_addr) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = sts_i.is_release ? S_FLUSH : S_PICK;
      end
      S_PICK: begin
        cmd_o.clr_cnt = 1'b1;
        state_d       = sts_i.need_steal ? S_STEAL : S_STORE;
      end
      S_STEAL: begin
        cmd_o.issue      = 1'b1;
        cmd_o.pass_steal = 1'b1;
        if (sts_i.last_addr) begin
          state_d = S_SDRAIN;
        end
      end
      S_SDRAIN: begin
        state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_FLUSH;
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

[rtl/rrva_dp.sv]
// ---------------------------------------------------------------------------
// Voice allocator datapath
// Held-note memory, scan compare, free-track search and result buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module rrva_dp
  import rrva_pkg::*;
#(
  parameter int unsigned TRACKS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       kind_i,
  input  logic [6:0] note_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic       out_strobe_o,
  output logic [4:0] track_o,
  output logic [6:0] note_value_o,
  output logic [7:0] instrument_out_o,
  output logic       last_o
);

  localparam int unsigned IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TRACKS - 1);

  // item registers
  logic             kind_q;
  logic [6:0]       n_q;
  logic [IDX_W-1:0] tcm1_q;
  logic [IDX_W-1:0] start_q;
  logic [IDX_W-1:0] last_track_q;

  // load-time values
  logic [8:0]       shift_sum;
  logic [6:0]       n_d;
  logic [IDX_W-1:0] tcm1_d;
  logic [IDX_W-1:0] start_d;

  // scan pipeline
  logic [IDX_W-1:0] cnt_q;
  logic             rd_v_q;
  logic             rd_steal_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [6:0]       rd_q;
  logic             rd_vld_q;
  logic [6:0]       rd_val;
  logic [6:0]       target;
  logic             hit;
  logic             scan1;
  logic             free;

  // search results
  logic             found_any_q;
  logic             found_ge_q;
  logic [IDX_W-1:0] any_q;
  logic [IDX_W-1:0] ge_q;
  logic [6:0]       hs_q;
  logic [IDX_W-1:0] pick_t;

  // note memory
  logic [6:0]        held_mem [TRACKS];
  logic [TRACKS-1:0] vld_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [6:0]        wr_data;

  // result buffer
  logic             push_v;
  logic [IDX_W-1:0] push_trk;
  logic [6:0]       push_note;
  logic             pend_v_q;
  logic [IDX_W-1:0] pend_trk_q;
  logic [6:0]       pend_note_q;
  logic             strobe_d;
  logic             out_strobe_q;
  logic [4:0]       out_trk_q;
  logic [6:0]       out_note_q;
  logic [7:0]       out_instr_q;
  logic             out_last_q;

  // octave shift with clamp, times twelve as two shifts
  assign shift_sum = {2'b00, note_i} + {2'b00, cfg_i.octave_shift, 3'b000}
                   + {3'b000, cfg_i.octave_shift, 2'b00};

  always_comb begin
    if (note_i >= NOTE_OFF) begin
      n_d = note_i;
    end else if (shift_sum > {2'b00, NOTE_TOP}) begin
      n_d = NOTE_TOP;
    end else begin
      n_d = shift_sum[6:0];
    end
  end

  // highest track index in use
  always_comb begin
    if (cfg_i.track_count == 6'd0) begin
      tcm1_d = '0;
    end else if (32'(cfg_i.track_count) > TRACKS) begin
      tcm1_d = IDX_MAX;
    end else begin
      tcm1_d = IDX_W'(cfg_i.track_count - 6'd1);
    end
  end

  // round-robin start, wraps to track 0 past the count
  assign start_d = (last_track_q >= tcm1_d) ? '0 : last_track_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      n_q     <= n_d;
      tcm1_q  <= tcm1_d;
      start_q <= start_d;
    end
  end

  // scan address counter and read-valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_v_q     <= 1'b0;
      rd_steal_q <= 1'b0;
    end else begin
      if (cmd_i.load || cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      rd_v_q     <= cmd_i.issue;
      rd_steal_q <= cmd_i.pass_steal;
    end
  end

  // compare stage
  assign rd_val = rd_vld_q ? rd_q : NOTE_OFF;
  assign target = rd_steal_q ? hs_q : n_q;
  assign hit    = rd_v_q && (rd_val == target);
  assign scan1  = rd_v_q && !rd_steal_q;
  assign free   = (rd_val == NOTE_OFF) || (rd_val == n_q);

  // first free track overall and first at or after the start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_any_q <= 1'b0;
      found_ge_q  <= 1'b0;
    end else if (cmd_i.load) begin
      found_any_q <= 1'b0;
      found_ge_q  <= 1'b0;
    end else if (scan1 && free) begin
      found_any_q <= 1'b1;
      if (rd_idx_q >= start_q) begin
        found_ge_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan1 && free && !found_any_q) begin
      any_q <= rd_idx_q;
    end
    if (scan1 && free && !found_ge_q && (rd_idx_q >= start_q)) begin
      ge_q <= rd_idx_q;
    end
    if (scan1 && (rd_idx_q == start_q)) begin
      hs_q <= rd_val;
    end
  end

  assign pick_t = found_ge_q  ? ge_q  :
                  found_any_q ? any_q : start_q;

  assign sts_o.last_addr  = (cnt_q == tcm1_q);
  assign sts_o.is_release = kind_q;
  assign sts_o.need_steal = !found_any_q && (hs_q < NOTE_OFF);

  // memory write: note-off on a hit, new note on store
  always_comb begin
    wr_en   = cmd_i.store || hit;
    wr_addr = cmd_i.store ? pick_t : rd_idx_q;
    wr_data = cmd_i.store ? n_q : NOTE_OFF;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      held_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.issue) begin
      rd_q     <= held_mem[cnt_q];
      rd_vld_q <= vld_q[cnt_q];
      rd_idx_q <= cnt_q;
    end
  end

  // written marks, an unwritten track reads as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // last used track
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_track_q <= '0;
    end else if (cmd_i.store) begin
      last_track_q <= pick_t;
    end
  end

  // one-beat hold so the final beat can carry last
  assign push_v    = hit || cmd_i.store;
  assign push_trk  = cmd_i.store ? pick_t : rd_idx_q;
  assign push_note = cmd_i.store ? n_q : NOTE_OFF;
  assign strobe_d  = pend_v_q && (push_v || cmd_i.flush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q     <= 1'b0;
      out_strobe_q <= 1'b0;
    end else begin
      if (push_v) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      out_strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_v) begin
      pend_trk_q  <= push_trk;
      pend_note_q <= push_note;
    end
    if (strobe_d) begin
      out_trk_q   <= 5'(pend_trk_q);
      out_note_q  <= pend_note_q;
      out_instr_q <= cfg_i.instrument;
      out_last_q  <= cmd_i.flush;
    end
  end

  assign out_strobe_o     = out_strobe_q;
  assign track_o          = out_trk_q;
  assign note_value_o     = out_note_q;
  assign instrument_out_o = out_instr_q;
  assign last_o           = out_last_q;

endmodule

`default_nettype wire

[rtl/round_robin_voice_allocator_unit.sv]
// ---------------------------------------------------------------------------
// Round-robin voice allocator
// Assigns key events to tracks, with note-off on release and voice stealing.
// ---------------------------------------------------------------------------
// An event is taken when start is high and busy is low. Each result beat is
// shown on the result ports for exactly one cycle with out_strobe_o high and
// cannot be held off; last_o marks the final beat of an event, and a release
// that frees no track gives no beats. The scan over the held-note memory
// reads one track per cycle on its single read port; the track count in
// use is 1 to TRACKS. The last beat appears in the first cycle with busy
// low. No clearing pass is needed after reset: per-track written bits make
// every track read as free until it is first written.
`default_nettype none

`include "round_robin_voice_allocator_unit_macros.svh"

module round_robin_voice_allocator_unit
  import rrva_pkg::*;
#(
  parameter int unsigned TRACKS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // event command
  input  logic              start,
  output logic              busy,
  input  logic              kind_i,
  input  logic [6:0]        note_i,
  // result beats
  output logic              out_strobe_o,
  output logic [4:0]        track_o,
  output logic [6:0]        note_value_o,
  output logic [7:0]        instrument_out_o,
  output logic              last_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  rrva_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  rrva_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath
  rrva_dp #(
    .TRACKS (TRACKS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .kind_i           (kind_i),
    .note_i           (note_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_strobe_o     (out_strobe_o),
    .track_o          (track_o),
    .note_value_o     (note_value_o),
    .instrument_out_o (instrument_out_o),
    .last_o           (last_o)
  );

  // an accepted event keeps the block busy
  `RRVA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // every beat comes out of work done while busy
  `RRVA_ASSERT_IMPL(a_beat_from_busy, clk_i, rst_ni, out_strobe_o, $past(busy))
  // the note-on is the final beat, following the store through the pending and output registers
  `RRVA_ASSERT_IMPL(a_store_last, clk_i, rst_ni, cmd.store, ##2 (out_strobe_o && last_o))
  // nothing follows the final beat directly
  `RRVA_ASSERT_NEXT(a_last_gap, clk_i, rst_ni, out_strobe_o && last_o, !out_strobe_o)

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// Voice allocator testbench
// Drives key press and release events into the allocator under a range of
// octave, track-count and instrument settings, and compares every note-on and
// note-off beat against an in-bench track allocation predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rrva_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TRACKS = 32;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 2 * NUM_TRACKS + 16;

  typedef enum bit {KEY_PRESS = 1'b0, KEY_RELEASE = 1'b1} kind_e;

  typedef struct {
    logic [4:0] track;
    logic [6:0] note_value;
    logic [7:0] instrument;
    logic       last;
  } track_event_t;

  // track allocation predictor and queue of due events
  class voice_tracker;
    logic [6:0]   held[NUM_TRACKS];
    int           last_trk;
    logic [3:0]   octave;
    logic [5:0]   tcount;
    logic [7:0]   instr;
    track_event_t due_events[$];
    int           keys_taken;
    int           steals;
    int           beats_checked;
    int           errors;

    function new();
      foreach (held[i]) held[i] = NOTE_OFF;
      last_trk = 0;
      octave   = OCTAVE_RST;
      tcount   = TRACKS_RST;
      instr    = INSTR_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_OCTAVE_SHIFT: octave = val[3:0];
        REG_TRACK_COUNT:  tcount = val[5:0];
        REG_INSTRUMENT:   instr  = val[7:0];
        default: ;
      endcase
    endfunction

    function int active_tracks();
      if (tcount == 0) return 1;
      if (tcount > NUM_TRACKS) return NUM_TRACKS;
      return tcount;
    endfunction

    function void push_event(int trk, int val);
      track_event_t ev;
      ev.track      = trk[4:0];
      ev.note_value = val[6:0];
      ev.instrument = instr;
      ev.last       = 1'b0;
      due_events = {due_events, ev};
    endfunction

    // note-off on every track in range holding the value
    function void release_note(int val);
      int tc;
      tc = active_tracks();
      for (int i = 0; i < tc; i++) begin
        if (held[i] == val) begin
          held[i] = NOTE_OFF;
          push_event(i, NOTE_OFF);
        end
      end
    endfunction

    // accepted key event: predict its beats
    function void take_key(kind_e k, logic [6:0] raw);
      int n, tc, first_idx, idx, pick, queued;
      bit found;
      keys_taken++;
      queued = due_events.size();
      n = raw;
      if (raw < NOTE_OFF) begin
        n = raw + 12 * octave;
        if (n > NOTE_TOP) n = NOTE_TOP;
      end
      release_note(n);
      if (k == KEY_PRESS) begin
        tc = active_tracks();
        first_idx = last_trk + 1;
        if (first_idx >= tc) first_idx = 0;
        pick  = first_idx;
        found = 1'b0;
        for (int j = 0; j < tc && !found; j++) begin
          idx = first_idx + j;
          if (idx >= tc) idx -= tc;
          if (held[idx] == NOTE_OFF) begin
            pick  = idx;
            found = 1'b1;
          end
        end
        // steal: stored note off unless it is a high code above note-off
        if (!found) begin
          steals++;
          if (held[pick] < NOTE_OFF) release_note(held[pick]);
        end
        held[pick] = n[6:0];
        last_trk   = pick;
        push_event(pick, n);
      end
      if (due_events.size() > queued) due_events[due_events.size() - 1].last = 1'b1;
    endfunction

    function void check_event(logic [4:0] trk, logic [6:0] nv, logic [7:0] ins, logic lst);
      track_event_t exp_ev;
      beats_checked++;
      if (due_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected beat: track %0d note %0d instr %0d last %0b",
                   $realtime, trk, nv, ins, lst);
        return;
      end
      exp_ev = due_events.pop_front();
      if (exp_ev.track !== trk || exp_ev.note_value !== nv ||
          exp_ev.instrument !== ins || exp_ev.last !== lst) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] beat mismatch: exp track %0d note %0d instr %0d last %0b,",
                    " got track %0d note %0d instr %0d last %0b"},
                   $realtime, exp_ev.track, exp_ev.note_value, exp_ev.instrument,
                   exp_ev.last, trk, nv, ins, lst);
      end
    endfunction
  endclass

  // clock, reset and block inputs
  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic              start   = 1'b0;
  logic              kind_i  = 1'b0;
  logic [6:0]        note_i  = '0;

  logic [31:0] prdata;
  logic        pready;
  logic        busy;
  logic        out_strobe_o;
  logic [4:0]  track_o;
  logic [6:0]  note_value_o;
  logic [7:0]  instrument_out_o;
  logic        last_o;

  voice_tracker sb = new();
  logic [6:0]   recent_notes[$];
  int           cycles = 0;
  int           settings_used = 0;

  always #4 clk_i = ~clk_i;

  round_robin_voice_allocator_unit #(
    .TRACKS(NUM_TRACKS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .note_i          (note_i),
    .out_strobe_o    (out_strobe_o),
    .track_o         (track_o),
    .note_value_o    (note_value_o),
    .instrument_out_o(instrument_out_o),
    .last_o          (last_o)
  );

  // result beats are taken at the edge that ends their cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) sb.check_event(track_o, note_value_o, instrument_out_o, last_o);
  end

  // cycle counter and timeout
  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d beats still due", cycles, sb.due_events.size());
    $display("Regression FAIL");
    $finish;
  end

  // one key event, held until the block takes it
  task automatic send_event(kind_e k, logic [6:0] n);
    start  <= 1'b1;
    kind_i <= k;
    note_i <= n;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.take_key(k, n);
  endtask

  // wait for every due beat
  task automatic wait_drained();
    do @(posedge clk_i); while (sb.due_events.size() != 0);
  endtask

  // setup and access cycle, back to back writes keep psel high
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // new settings only once the block is quiet
  task automatic apply_settings(int oct, int tc, int ins);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_OCTAVE_SHIFT, 32'(oct));
    write_reg(REG_TRACK_COUNT, 32'(tc));
    write_reg(REG_INSTRUMENT, 32'(ins));
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // random events, releases mostly of recently pressed keys
  task automatic run_phase(int count, bit quiet, bit hold_midway);
    kind_e      k;
    logic [6:0] n;
    for (int i = 0; i < count; i++) begin
      if (hold_midway && i == count / 2) begin
        start <= 1'b0;
        wait_drained();
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      k = ($urandom_range(0, 99) < 55) ? KEY_PRESS : KEY_RELEASE;
      if (recent_notes.size() > 0 &&
          $urandom_range(0, 99) < ((k == KEY_RELEASE) ? 75 : 20))
        n = recent_notes[$urandom_range(0, recent_notes.size() - 1)];
      else
        n = 7'($urandom_range(0, 127));
      if (k == KEY_PRESS) begin
        recent_notes = {recent_notes, n};
        if (recent_notes.size() > 8) recent_notes.delete(0);
      end
      send_event(k, n);
    end
    start <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // three tracks: empty release, high codes, steals, note-off floods
    apply_settings(0, 3, 8'hA5);
    send_event(KEY_RELEASE, 7'd10);
    send_event(KEY_PRESS, 7'd0);
    send_event(KEY_PRESS, 7'd127);
    send_event(KEY_PRESS, 7'd119);
    send_event(KEY_PRESS, 7'd50);
    send_event(KEY_PRESS, 7'd60);
    send_event(KEY_PRESS, 7'd50);
    send_event(KEY_RELEASE, 7'd120);
    send_event(KEY_PRESS, 7'd120);
    send_event(KEY_RELEASE, 7'd119);
    send_event(KEY_RELEASE, 7'd127);
    send_event(KEY_RELEASE, 7'd50);
    send_event(KEY_RELEASE, 7'd60);
    start <= 1'b0;

    // zero track count behaves as one, top octave clamps
    apply_settings(9, 0, 8'hFF);
    send_event(KEY_PRESS, 7'd5);
    send_event(KEY_PRESS, 7'd11);
    send_event(KEY_PRESS, 7'd100);
    send_event(KEY_RELEASE, 7'd119);
    start <= 1'b0;

    // oversized count and octave field at its all-ones value
    apply_settings(15, 63, 8'h00);
    send_event(KEY_PRESS, 7'd120);
    send_event(KEY_PRESS, 7'd0);
    send_event(KEY_PRESS, 7'd127);
    send_event(KEY_PRESS, 7'd64);
    start <= 1'b0;

    // shrink count below the last used track
    apply_settings(4, 2, 8'h5A);
    send_event(KEY_PRESS, 7'd64);
    send_event(KEY_RELEASE, 7'd127);
    send_event(KEY_PRESS, 7'd10);
    start <= 1'b0;

    // random phases over several settings
    apply_settings(0, 1, $urandom_range(0, 255));
    run_phase(64, 1'b0, 1'b0);
    apply_settings(9, 4, $urandom_range(0, 255));
    run_phase(64, 1'b0, 1'b0);
    apply_settings($urandom_range(0, 9), 32, 0);
    run_phase(64, 1'b0, 1'b1);
    apply_settings($urandom_range(0, 9), $urandom_range(2, 8), $urandom_range(0, 255));
    run_phase(64, 1'b0, 1'b0);
    apply_settings($urandom_range(0, 9), $urandom_range(9, 31), $urandom_range(0, 255));
    run_phase(64, 1'b0, 1'b0);
    apply_settings($urandom_range(0, 9), $urandom_range(2, 6), 255);
    run_phase(64, 1'b1, 1'b0);

    // drain and let any trailing beat show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.due_events.size() != 0) begin
      sb.errors += sb.due_events.size();
      $display("%0d beats never arrived", sb.due_events.size());
    end

    $display("covered %0d key events under %0d settings, %0d of them stealing a track",
             sb.keys_taken, settings_used, sb.steals);
    $display("checked %0d result beats, %0d mismatches", sb.beats_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
